// ===== design/ibtm_pkg.sv =====
// ----------------------------------------------------------------------------
// ibtm_pkg
// Shared constants, controller states and the command and status words that
// pass between the trie controller and the trie datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibtm_pkg;

   localparam int NODE_COUNT = 256;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int FREE_W     = NODE_W + 1;
   localparam int SLOT_W     = 8;
   localparam int MEM_AW     = NODE_W + SLOT_W;
   localparam int ADDR_W     = 32;
   localparam int LEVEL_W    = 2;

   localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;
   localparam logic [NODE_W-1:0]  LEAF_MARK  = NODE_W'(1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_ALLOC = 6'b010000,
      ST_MARK  = 6'b100000
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic descend;
      logic alloc;
      logic mark_leaf;
      logic respond;
      logic found;
      logic full;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic link_zero;
      logic last_level;
      logic next_is_last;
      logic op_insert;
      logic fits;
   } status_type;

endpackage

`default_nettype wire

// ===== design/ibtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibtm_ctrl
// Sequencer for the trie: clearing pass, level-by-level walk, node
// allocation and the result strobe command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibtm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire ibtm_pkg::status_type status,
   output ibtm_pkg::cmd_type         cmd
);

   ibtm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ibtm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ibtm_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ibtm_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ibtm_pkg::ST_IDLE;
            end
         end
         ibtm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ibtm_pkg::ST_READ;
            end
         end
         ibtm_pkg::ST_READ: begin
            state_in = ibtm_pkg::ST_CHECK;
         end
         ibtm_pkg::ST_CHECK: begin
            if (status.last_level) begin
               if (!status.link_zero) begin
                  cmd.respond = 1'b1;
                  cmd.found   = 1'b1;
                  state_in    = ibtm_pkg::ST_IDLE;
               end else if (status.op_insert) begin
                  state_in = ibtm_pkg::ST_MARK;
               end else begin
                  cmd.respond = 1'b1;
                  state_in    = ibtm_pkg::ST_IDLE;
               end
            end else if (!status.link_zero) begin
               cmd.descend = 1'b1;
               state_in    = ibtm_pkg::ST_READ;
            end else if (!status.op_insert) begin
               cmd.respond = 1'b1;
               state_in    = ibtm_pkg::ST_IDLE;
            end else if (!status.fits) begin
               cmd.respond = 1'b1;
               cmd.full    = 1'b1;
               state_in    = ibtm_pkg::ST_IDLE;
            end else begin
               state_in = ibtm_pkg::ST_ALLOC;
            end
         end
         ibtm_pkg::ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (status.next_is_last) begin
               state_in = ibtm_pkg::ST_MARK;
            end
         end
         ibtm_pkg::ST_MARK: begin
            cmd.mark_leaf = 1'b1;
            cmd.respond   = 1'b1;
            state_in      = ibtm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ibtm_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/ibtm_datapath.sv =====
// ----------------------------------------------------------------------------
// ibtm_datapath
// Link memory, walk registers, free-node counter, clearing counter and the
// result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibtm_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_op,
   input  wire logic [ibtm_pkg::ADDR_W-1:0]         req_address,
   input  wire ibtm_pkg::cmd_type                   cmd,
   output ibtm_pkg::status_type                     status,
   output logic                                     rsp_strobe,
   output logic                                     rsp_found,
   output logic                                     rsp_pool_full
);

   logic [ibtm_pkg::NODE_W-1:0] link_mem [2**ibtm_pkg::MEM_AW];

   logic                          op_ff;
   logic [ibtm_pkg::ADDR_W-1:0]   addr_ff;
   logic [ibtm_pkg::NODE_W-1:0]   node_ff, node_in;
   logic [ibtm_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [ibtm_pkg::FREE_W-1:0]   free_ff, free_in;
   logic [ibtm_pkg::MEM_AW-1:0]   clr_addr_ff;
   logic [ibtm_pkg::NODE_W-1:0]   rdata_ff;
   logic                          strobe_ff, found_ff, full_ff;

   logic [ibtm_pkg::SLOT_W-1:0]   slot;
   logic [ibtm_pkg::MEM_AW-1:0]   walk_addr, waddr;
   logic [ibtm_pkg::NODE_W-1:0]   wdata;
   logic                          we;
   logic [ibtm_pkg::FREE_W:0]     need_end;

   // byte of the address that the current level selects
   always_comb begin
      case (level_ff)
         2'd0:    slot = addr_ff[31:24];
         2'd1:    slot = addr_ff[23:16];
         2'd2:    slot = addr_ff[15:8];
         default: slot = addr_ff[7:0];
      endcase
   end

   assign walk_addr = {node_ff, slot};

   always_comb begin
      we    = 1'b0;
      waddr = walk_addr;
      wdata = ibtm_pkg::LEAF_MARK;
      if (cmd.clear) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
         wdata = '0;
      end else if (cmd.alloc) begin
         we    = 1'b1;
         wdata = free_ff[ibtm_pkg::NODE_W-1:0];
      end else if (cmd.mark_leaf) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         link_mem[waddr] <= wdata;
      end
      rdata_ff <= link_mem[walk_addr];
   end

   always_comb begin
      node_in  = node_ff;
      level_in = level_ff;
      free_in  = free_ff;
      if (cmd.load) begin
         node_in  = '0;
         level_in = '0;
      end else if (cmd.descend) begin
         node_in  = rdata_ff;
         level_in = level_ff + 2'd1;
      end else if (cmd.alloc) begin
         node_in  = free_ff[ibtm_pkg::NODE_W-1:0];
         level_in = level_ff + 2'd1;
         free_in  = free_ff + ibtm_pkg::FREE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff     <= ibtm_pkg::FREE_W'(1);
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         free_ff     <= free_in;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + ibtm_pkg::MEM_AW'(1);
         end
         strobe_ff   <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      node_ff  <= node_in;
      level_ff <= level_in;
      if (cmd.load) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
      end
      if (cmd.respond) begin
         found_ff <= cmd.found;
         full_ff  <= cmd.full;
      end
   end

   // nodes still missing below this level: 3 - level
   assign need_end = {1'b0, free_ff}
                   + (ibtm_pkg::FREE_W + 1)'(ibtm_pkg::LAST_LEVEL - level_ff);

   assign status.clear_last   = (clr_addr_ff == {ibtm_pkg::MEM_AW{1'b1}});
   assign status.link_zero    = (rdata_ff == '0);
   assign status.last_level   = (level_ff == ibtm_pkg::LAST_LEVEL);
   assign status.next_is_last = (level_ff == ibtm_pkg::LAST_LEVEL - 2'd1);
   assign status.op_insert    = op_ff;
   assign status.fits         = (need_end <= (ibtm_pkg::FREE_W + 1)'(ibtm_pkg::NODE_COUNT));

   assign rsp_strobe    = strobe_ff;
   assign rsp_found     = found_ff;
   assign rsp_pool_full = full_ff;

endmodule

`default_nettype wire

// ===== design/ipv4_byte_trie_membership_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_byte_trie_membership_unit
// Exact-match set of IPv4 addresses held as a four-level trie of 256-way
// nodes.
// ----------------------------------------------------------------------------
// usage:
//  - a word is taken at a clock edge with start high and busy low: req_op
//    (0 lookup, 1 insert) and req_address
//  - one result word per request: rsp_strobe high for one cycle with
//    rsp_found (address present before the request) and rsp_pool_full
//    (insert rejected, no change made)
//  - each level takes a registered link memory read and then a check; a
//    lookup walks one to four levels between acceptance and strobe
//  - an insert adds one allocation step per missing interior node and then
//    the leaf mark step
//  - the link memory read and check walk sets the rate: one request at
//    a time, the next accepted once busy drops, also while the last
//    result is on the strobe
//  - after reset a clearing pass zeroes all 65536 links, one per cycle;
//    busy is high throughout the pass and no request is taken
//  - the receiver cannot stall; rsp_strobe marks the result for one cycle only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4_byte_trie_membership_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_op,
   input  wire logic [ibtm_pkg::ADDR_W-1:0] req_address,
   output logic                             rsp_strobe,
   output logic                             rsp_found,
   output logic                             rsp_pool_full
);

   ibtm_pkg::cmd_type    cmd;
   ibtm_pkg::status_type status;

   ibtm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ibtm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_address   (req_address),
      .cmd           (cmd),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_found     (rsp_found),
      .rsp_pool_full (rsp_pool_full)
   );

endmodule

`default_nettype wire
